### sv/nnis_pkg.sv
// ----------------------------------------------------------------------------
// Nearest-neighbor scaler package
// Shared types, codes and default sizes of the image scaler.
// ----------------------------------------------------------------------------
package nnis_pkg;

  localparam int DefMaxWidth   = 4096;
  localparam int DefMaxSamples = 4;
  localparam int DefSampleBits = 16;

  localparam int NumSamplePorts = 4;
  localparam int PortSampleW    = 16;
  localparam int WidthRegW      = 13;
  localparam int HeightW        = 16;
  localparam int SppW           = 3;
  localparam int DestXW         = 12;
  localparam int CfgIdxW        = 3;
  localparam int CfgDataW       = 16;
  localparam int QDepth         = 4;

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_FETCH = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ST_WRITE_OK = 2'd0,
    ST_PIXEL    = 2'd1,
    ST_WAIT     = 2'd2,
    ST_REFUSED  = 2'd3
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_SRC_WIDTH  = 3'd0,
    REG_SRC_HEIGHT = 3'd1,
    REG_DST_WIDTH  = 3'd2,
    REG_DST_HEIGHT = 3'd3,
    REG_SAMPLES    = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    status_e             status;
    logic [DestXW-1:0]   dest_x;
    logic [HeightW-1:0]  dest_y;
    logic                row_end;
    logic                frame_end;
  } meta_t;

  typedef struct packed {
    meta_t                                       meta;
    logic [NumSamplePorts-1:0][PortSampleW-1:0]  samples;
  } result_t;

endpackage

### sv/nnis_div.sv
// ----------------------------------------------------------------------------
// Step divider
// Bit-serial restoring divider with a column lane and a row lane, one quotient
// bit per cycle, giving the per-pixel step and remainder of both axes.
// ----------------------------------------------------------------------------
module nnis_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [nnis_pkg::WidthRegW-1:0] col_num_i,
  input  logic [nnis_pkg::WidthRegW-1:0] col_den_i,
  input  logic [nnis_pkg::HeightW-1:0]   row_num_i,
  input  logic [nnis_pkg::HeightW-1:0]   row_den_i,
  output logic                          busy_o,
  output logic [nnis_pkg::WidthRegW-1:0] col_quo_o,
  output logic [nnis_pkg::WidthRegW-1:0] col_rem_o,
  output logic [nnis_pkg::HeightW-1:0]   row_quo_o,
  output logic [nnis_pkg::HeightW-1:0]   row_rem_o
);
  import nnis_pkg::*;

  localparam int LaneW = HeightW;
  localparam int CntW  = $clog2(LaneW);

  logic [LaneW-1:0] num [2];
  logic [LaneW-1:0] den [2];
  logic [LaneW-1:0] rem_q [2];
  logic [LaneW-1:0] rem_d [2];
  logic [LaneW-1:0] quo_q [2];
  logic [LaneW-1:0] quo_d [2];
  logic [LaneW:0]   shifted [2];
  logic [CntW-1:0]  cnt_q;
  logic             busy_q;

  assign num[0] = LaneW'(col_num_i);
  assign den[0] = LaneW'(col_den_i);
  assign num[1] = row_num_i;
  assign den[1] = row_den_i;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      shifted[l] = {rem_q[l], num[l][~cnt_q]};
      if (shifted[l] >= {1'b0, den[l]}) begin
        rem_d[l] = LaneW'(shifted[l] - {1'b0, den[l]});
        quo_d[l] = {quo_q[l][LaneW-2:0], 1'b1};
      end else begin
        rem_d[l] = shifted[l][LaneW-1:0];
        quo_d[l] = {quo_q[l][LaneW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
      for (int l = 0; l < 2; l++) begin
        rem_q[l] <= '0;
        quo_q[l] <= '0;
      end
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
      for (int l = 0; l < 2; l++) begin
        rem_q[l] <= '0;
        quo_q[l] <= '0;
      end
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == CntW'(LaneW - 1)) begin
        busy_q <= 1'b0;
      end
      for (int l = 0; l < 2; l++) begin
        rem_q[l] <= rem_d[l];
        quo_q[l] <= quo_d[l];
      end
    end
  end

  assign busy_o    = busy_q;
  assign col_quo_o = WidthRegW'(quo_q[0]);
  assign col_rem_o = WidthRegW'(rem_q[0]);
  assign row_quo_o = quo_q[1];
  assign row_rem_o = rem_q[1];

  a_div_finishes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && cnt_q == CntW'(LaneW - 1) && !start_i |=> !busy_q)
    else $error("divider did not finish after last step");

endmodule

### sv/nnis_front.sv
// ----------------------------------------------------------------------------
// Scaler front end
// Holds the configuration, classifies each command against the loaded row,
// steps the write and fetch positions and accesses the line store.
// ----------------------------------------------------------------------------
module nnis_front #(
  parameter int MAX_WIDTH   = nnis_pkg::DefMaxWidth,
  parameter int MAX_SAMPLES = nnis_pkg::DefMaxSamples,
  parameter int SAMPLE_BITS = nnis_pkg::DefSampleBits
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        cfg_we_i,
  input  logic [nnis_pkg::CfgIdxW-1:0]                cfg_idx_i,
  input  logic [nnis_pkg::CfgDataW-1:0]               cfg_data_i,
  input  logic                                        accept_i,
  input  logic                                        command_i,
  input  logic [nnis_pkg::NumSamplePorts-1:0][nnis_pkg::PortSampleW-1:0] samples_i,
  output logic                                        busy_o,
  output logic                                        stg_valid_o,
  output nnis_pkg::meta_t                             stg_meta_o,
  output logic [MAX_SAMPLES*SAMPLE_BITS-1:0]          stg_data_o
);
  import nnis_pkg::*;

  localparam int AddrW = $clog2(MAX_WIDTH);
  localparam int SlotW = MAX_SAMPLES * SAMPLE_BITS;
  localparam logic [WidthRegW-1:0] WidthClamp =
    WidthRegW'((MAX_WIDTH > 8191) ? 8191 : MAX_WIDTH);
  localparam logic [SppW-1:0] SppClamp = SppW'(MAX_SAMPLES);
  localparam logic [HeightW:0] NoRow = {1'b1, {HeightW{1'b0}}};

  logic [WidthRegW-1:0] src_w_q, dst_w_q;
  logic [HeightW-1:0]   src_h_q, dst_h_q;
  logic [SppW-1:0]      spp_q;
  logic                 cfg_hit;

  logic [WidthRegW-1:0] sw, dw;
  logic [HeightW-1:0]   sh, dh;
  logic [SppW-1:0]      spp;

  logic [WidthRegW-1:0] col_quo, col_rem;
  logic [HeightW-1:0]   row_quo, row_rem;
  logic                 div_busy;

  logic [WidthRegW-1:0] wcol_q, wcol_d, fcol_q, fcol_d, csrc_q, csrc_d, crem_q, crem_d;
  logic [HeightW-1:0]   wrow_q, wrow_d, frow_q, frow_d, rsrc_q, rsrc_d, rrem_q, rrem_d;
  logic [HeightW:0]     lrow_q, lrow_d;

  logic                 row_hit, row_end, frame_end, wcol_last;
  logic [WidthRegW:0]   crem_sum;
  logic [HeightW:0]     rrem_sum;
  logic [WidthRegW-1:0] csrc_sum;
  logic [HeightW-1:0]   rsrc_sum;

  logic                 mem_we, mem_re;
  logic [AddrW-1:0]     mem_waddr, mem_raddr;
  logic [SlotW-1:0]     mem_wdata;
  logic [SlotW-1:0]     line_mem_q [MAX_WIDTH];
  logic [SlotW-1:0]     rdata_q;

  logic                 stg_valid_q;
  meta_t                meta_d, stg_meta_q;

  always_comb begin
    cfg_hit = 1'b0;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        REG_SRC_WIDTH, REG_SRC_HEIGHT, REG_DST_WIDTH,
        REG_DST_HEIGHT, REG_SAMPLES: cfg_hit = 1'b1;
        default:                     cfg_hit = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_w_q <= WidthRegW'(1);
      src_h_q <= HeightW'(1);
      dst_w_q <= WidthRegW'(1);
      dst_h_q <= HeightW'(1);
      spp_q   <= SppW'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        REG_SRC_WIDTH:  src_w_q <= cfg_data_i[WidthRegW-1:0];
        REG_SRC_HEIGHT: src_h_q <= cfg_data_i[HeightW-1:0];
        REG_DST_WIDTH:  dst_w_q <= cfg_data_i[WidthRegW-1:0];
        REG_DST_HEIGHT: dst_h_q <= cfg_data_i[HeightW-1:0];
        REG_SAMPLES:    spp_q   <= cfg_data_i[SppW-1:0];
        default: ;
      endcase
    end
  end

  // effective values: zero acts as one, oversize is clamped
  always_comb begin
    sw = src_w_q;
    if (src_w_q == '0) sw = WidthRegW'(1);
    else if (32'(src_w_q) > MAX_WIDTH) sw = WidthClamp;
    dw = dst_w_q;
    if (dst_w_q == '0) dw = WidthRegW'(1);
    else if (32'(dst_w_q) > MAX_WIDTH) dw = WidthClamp;
    sh  = (src_h_q == '0) ? HeightW'(1) : src_h_q;
    dh  = (dst_h_q == '0) ? HeightW'(1) : dst_h_q;
    spp = spp_q;
    if (spp_q == '0) spp = SppW'(1);
    else if (spp_q > SppClamp) spp = SppClamp;
  end

  nnis_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (cfg_hit),
    .col_num_i (sw),
    .col_den_i (dw),
    .row_num_i (sh),
    .row_den_i (dh),
    .busy_o    (div_busy),
    .col_quo_o (col_quo),
    .col_rem_o (col_rem),
    .row_quo_o (row_quo),
    .row_rem_o (row_rem)
  );

  assign row_hit   = (lrow_q == {1'b0, rsrc_q});
  assign wcol_last = ((WidthRegW+1)'(wcol_q) + 1'b1) >= (WidthRegW+1)'(sw);
  assign row_end   = ((WidthRegW+1)'(fcol_q) + 1'b1) >= (WidthRegW+1)'(dw);
  assign frame_end = row_end && (((HeightW+1)'(frow_q) + 1'b1) >= (HeightW+1)'(dh));
  assign crem_sum  = (WidthRegW+1)'(crem_q) + (WidthRegW+1)'(col_rem);
  assign rrem_sum  = (HeightW+1)'(rrem_q) + (HeightW+1)'(row_rem);
  assign csrc_sum  = csrc_q + col_quo;
  assign rsrc_sum  = rsrc_q + row_quo;

  always_comb begin
    for (int g = 0; g < MAX_SAMPLES; g++) begin
      mem_wdata[g*SAMPLE_BITS +: SAMPLE_BITS] =
        (SppW'(g) < spp) ? samples_i[g][SAMPLE_BITS-1:0] : '0;
    end
  end

  assign mem_waddr = AddrW'(wcol_q);
  assign mem_raddr = AddrW'(csrc_q);

  always_comb begin
    wcol_d = wcol_q;
    wrow_d = wrow_q;
    lrow_d = lrow_q;
    fcol_d = fcol_q;
    frow_d = frow_q;
    csrc_d = csrc_q;
    crem_d = crem_q;
    rsrc_d = rsrc_q;
    rrem_d = rrem_q;
    mem_we = 1'b0;
    mem_re = 1'b0;
    meta_d = '0;
    if (accept_i) begin
      if (cmd_e'(command_i) == CMD_WRITE) begin
        if (row_hit) begin
          meta_d.status = ST_REFUSED;
        end else begin
          meta_d.status = ST_WRITE_OK;
          mem_we = 1'b1;
          if (wcol_last) begin
            lrow_d = {1'b0, wrow_q};
            wcol_d = '0;
            wrow_d = (((HeightW+1)'(wrow_q) + 1'b1) >= (HeightW+1)'(sh)) ? '0
                                                                       : wrow_q + 1'b1;
          end else begin
            lrow_d = NoRow;
            wcol_d = wcol_q + 1'b1;
          end
        end
      end else if (!row_hit) begin
        meta_d.status = ST_WAIT;
      end else begin
        mem_re           = 1'b1;
        meta_d.status    = ST_PIXEL;
        meta_d.dest_x    = DestXW'(fcol_q);
        meta_d.dest_y    = frow_q;
        meta_d.row_end   = row_end;
        meta_d.frame_end = frame_end;
        if (!row_end) begin
          fcol_d = fcol_q + 1'b1;
          if (crem_sum >= (WidthRegW+1)'(dw)) begin
            crem_d = WidthRegW'(crem_sum - (WidthRegW+1)'(dw));
            csrc_d = csrc_sum + 1'b1;
          end else begin
            crem_d = WidthRegW'(crem_sum);
            csrc_d = csrc_sum;
          end
        end else begin
          fcol_d = '0;
          csrc_d = '0;
          crem_d = '0;
          if (frame_end) begin
            frow_d = '0;
            rsrc_d = '0;
            rrem_d = '0;
            lrow_d = NoRow;
          end else begin
            frow_d = frow_q + 1'b1;
            if (rrem_sum >= (HeightW+1)'(dh)) begin
              rrem_d = HeightW'(rrem_sum - (HeightW+1)'(dh));
              rsrc_d = rsrc_sum + 1'b1;
            end else begin
              rrem_d = HeightW'(rrem_sum);
              rsrc_d = rsrc_sum;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wcol_q      <= '0;
      wrow_q      <= '0;
      lrow_q      <= NoRow;
      fcol_q      <= '0;
      frow_q      <= '0;
      csrc_q      <= '0;
      crem_q      <= '0;
      rsrc_q      <= '0;
      rrem_q      <= '0;
      stg_valid_q <= 1'b0;
    end else begin
      stg_valid_q <= accept_i;
      if (cfg_hit) begin
        wcol_q <= '0;
        wrow_q <= '0;
        lrow_q <= NoRow;
        fcol_q <= '0;
        frow_q <= '0;
        csrc_q <= '0;
        crem_q <= '0;
        rsrc_q <= '0;
        rrem_q <= '0;
      end else begin
        wcol_q <= wcol_d;
        wrow_q <= wrow_d;
        lrow_q <= lrow_d;
        fcol_q <= fcol_d;
        frow_q <= frow_d;
        csrc_q <= csrc_d;
        crem_q <= crem_d;
        rsrc_q <= rsrc_d;
        rrem_q <= rrem_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      line_mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= line_mem_q[mem_raddr];
    end
    stg_meta_q <= meta_d;
  end

  assign busy_o      = div_busy;
  assign stg_valid_o = stg_valid_q;
  assign stg_meta_o  = stg_meta_q;
  assign stg_data_o  = rdata_q;

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i |-> !div_busy)
    else $error("item accepted while step divider busy");

  a_col_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    crem_q < dw)
    else $error("column remainder out of range");

  a_row_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rrem_q < dh)
    else $error("row remainder out of range");

endmodule

### sv/nnis_back.sv
// ----------------------------------------------------------------------------
// Scaler back end
// Formats each classified item into a result and queues it for the consumer.
// ----------------------------------------------------------------------------
module nnis_back #(
  parameter int MAX_SAMPLES = nnis_pkg::DefMaxSamples,
  parameter int SAMPLE_BITS = nnis_pkg::DefSampleBits
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               stg_valid_i,
  input  nnis_pkg::meta_t                    stg_meta_i,
  input  logic [MAX_SAMPLES*SAMPLE_BITS-1:0] stg_data_i,
  input  logic                               pop_i,
  output logic                               room_o,
  output logic                               empty_o,
  output nnis_pkg::result_t                  head_o
);
  import nnis_pkg::*;

  localparam int PtrW = $clog2(QDepth);
  localparam int CntW = $clog2(QDepth + 1);

  result_t         res;
  result_t         q_mem_q [QDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_pop;

  always_comb begin
    res.meta    = stg_meta_i;
    res.samples = '0;
    if (stg_meta_i.status == ST_PIXEL) begin
      for (int g = 0; g < MAX_SAMPLES; g++) begin
        res.samples[g] = PortSampleW'(stg_data_i[g*SAMPLE_BITS +: SAMPLE_BITS]);
      end
    end
  end

  assign do_pop  = pop_i && (cnt_q != '0);
  assign empty_o = (cnt_q == '0);
  assign room_o  = ((CntW+1)'(cnt_q) + (CntW+1)'(stg_valid_i)) < (CntW+1)'(QDepth);
  assign head_o  = q_mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (stg_valid_i) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (do_pop)      rd_ptr_q <= rd_ptr_q + 1'b1;
      cnt_q <= cnt_q + CntW'(stg_valid_i) - CntW'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (stg_valid_i) begin
      q_mem_q[wr_ptr_q] <= res;
    end
  end

  a_push_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stg_valid_i |-> cnt_q < CntW'(QDepth))
    else $error("result pushed into full queue");

  a_cnt_tracks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !stg_valid_i && !do_pop |=> $stable(cnt_q))
    else $error("queue count moved without transfer");

endmodule

### sv/nearest_neighbour_image_scaler_unit.sv
// ----------------------------------------------------------------------------
// Nearest-neighbor image scaler
// Top level: configuration port, command queue side and result queue side.
// ----------------------------------------------------------------------------
// The scaler takes one command per clock while full is low, write or fetch, and
// returns one result per command in order, through the staging registers and
// the result queue. Source pixels go into a single-row line store of MAX_WIDTH
// entries with one write or read port per cycle. The per-pixel column and row
// steps come from a bit-serial divider: after reset and after every register
// write, full stays high while it runs. A four-entry result queue lets the
// command side keep going while results wait to be popped.
module nearest_neighbour_image_scaler_unit #(
  parameter int MAX_WIDTH   = nnis_pkg::DefMaxWidth,
  parameter int MAX_SAMPLES = nnis_pkg::DefMaxSamples,
  parameter int SAMPLE_BITS = nnis_pkg::DefSampleBits
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [nnis_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [nnis_pkg::CfgDataW-1:0]    cfg_data_i,
  input  logic                             push,
  output logic                             full,
  input  logic                             command_i,
  input  logic [nnis_pkg::PortSampleW-1:0] in_sample0_i,
  input  logic [nnis_pkg::PortSampleW-1:0] in_sample1_i,
  input  logic [nnis_pkg::PortSampleW-1:0] in_sample2_i,
  input  logic [nnis_pkg::PortSampleW-1:0] in_sample3_i,
  output logic                             empty,
  input  logic                             pop,
  output logic [1:0]                       status_o,
  output logic [nnis_pkg::PortSampleW-1:0] out_sample0_o,
  output logic [nnis_pkg::PortSampleW-1:0] out_sample1_o,
  output logic [nnis_pkg::PortSampleW-1:0] out_sample2_o,
  output logic [nnis_pkg::PortSampleW-1:0] out_sample3_o,
  output logic [nnis_pkg::DestXW-1:0]      dest_x_o,
  output logic [nnis_pkg::HeightW-1:0]     dest_y_o,
  output logic                             row_end_o,
  output logic                             frame_end_o
);
  import nnis_pkg::*;

  logic                                       accept, busy, room, stg_valid;
  logic [NumSamplePorts-1:0][PortSampleW-1:0] samples;
  meta_t                                      stg_meta;
  logic [MAX_SAMPLES*SAMPLE_BITS-1:0]         stg_data;
  result_t                                    head;

  assign samples = {in_sample3_i, in_sample2_i, in_sample1_i, in_sample0_i};
  assign full    = busy || !room;
  assign accept  = push && !full;

  nnis_front #(
    .MAX_WIDTH   (MAX_WIDTH),
    .MAX_SAMPLES (MAX_SAMPLES),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .accept_i    (accept),
    .command_i   (command_i),
    .samples_i   (samples),
    .busy_o      (busy),
    .stg_valid_o (stg_valid),
    .stg_meta_o  (stg_meta),
    .stg_data_o  (stg_data)
  );

  nnis_back #(
    .MAX_SAMPLES (MAX_SAMPLES),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .stg_valid_i (stg_valid),
    .stg_meta_i  (stg_meta),
    .stg_data_i  (stg_data),
    .pop_i       (pop),
    .room_o      (room),
    .empty_o     (empty),
    .head_o      (head)
  );

  assign status_o      = head.meta.status;
  assign out_sample0_o = head.samples[0];
  assign out_sample1_o = head.samples[1];
  assign out_sample2_o = head.samples[2];
  assign out_sample3_o = head.samples[3];
  assign dest_x_o      = head.meta.dest_x;
  assign dest_y_o      = head.meta.dest_y;
  assign row_end_o     = head.meta.row_end;
  assign frame_end_o   = head.meta.frame_end;

endmodule

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// Nearest-neighbor image scaler testbench
// Drives write and fetch commands through the command queue with random gaps,
// pops results with random stalls, and checks every result field against a
// cycle-free model of the line buffer and the column and row step counters.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import nnis_pkg::*;

  localparam int            LineLen = DefMaxWidth;
  localparam logic [16:0]   NoRow   = 17'h10000;

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic [CfgIdxW-1:0]     cfg_idx_i;
  logic [CfgDataW-1:0]    cfg_data_i;
  logic                   push;
  logic                   full;
  logic                   command_i;
  logic [PortSampleW-1:0] in_sample0_i, in_sample1_i, in_sample2_i, in_sample3_i;
  logic                   empty;
  logic                   pop;
  logic [1:0]             status_o;
  logic [PortSampleW-1:0] out_sample0_o, out_sample1_o, out_sample2_o, out_sample3_o;
  logic [DestXW-1:0]      dest_x_o;
  logic [HeightW-1:0]     dest_y_o;
  logic                   row_end_o;
  logic                   frame_end_o;

  always #5 clk_i = ~clk_i;

  nearest_neighbour_image_scaler_unit u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .push          (push),
    .full          (full),
    .command_i     (command_i),
    .in_sample0_i  (in_sample0_i),
    .in_sample1_i  (in_sample1_i),
    .in_sample2_i  (in_sample2_i),
    .in_sample3_i  (in_sample3_i),
    .empty         (empty),
    .pop           (pop),
    .status_o      (status_o),
    .out_sample0_o (out_sample0_o),
    .out_sample1_o (out_sample1_o),
    .out_sample2_o (out_sample2_o),
    .out_sample3_o (out_sample3_o),
    .dest_x_o      (dest_x_o),
    .dest_y_o      (dest_y_o),
    .row_end_o     (row_end_o),
    .frame_end_o   (frame_end_o)
  );

  // Scaler state as seen by the testbench
  logic [15:0] pixel_line [LineLen][NumSamplePorts];
  logic [12:0] src_w_reg = 13'd1;
  logic [15:0] src_h_reg = 16'd1;
  logic [12:0] dst_w_reg = 13'd1;
  logic [15:0] dst_h_reg = 16'd1;
  logic [2:0]  spp_reg   = 3'd1;
  logic [11:0] wr_col     = '0;
  logic [15:0] wr_row     = '0;
  logic [16:0] loaded_row = NoRow;
  logic [11:0] fe_col     = '0;
  logic [15:0] fe_row     = '0;
  logic [11:0] col_src    = '0;
  logic [12:0] col_rem    = '0;
  logic [15:0] row_src    = '0;
  logic [16:0] row_rem    = '0;

  result_t     pending_results[$];
  int unsigned mismatches = 0;
  bit          no_idle    = 1'b0;
  int          send_calm  = 0;

  function automatic int unsigned eff_width(logic [12:0] v);
    if (v == 0) return 1;
    if (v > LineLen) return LineLen;
    return v;
  endfunction

  function automatic int unsigned eff_height(logic [15:0] v);
    return (v == 0) ? 1 : v;
  endfunction

  function automatic int unsigned eff_samples(logic [2:0] v);
    if (v == 0) return 1;
    if (v > DefMaxSamples) return DefMaxSamples;
    return v;
  endfunction

  // Mostly short gaps, a few long ones, and calm stretches with none
  function automatic int pick_gap(inout int calm);
    int r;
    if (no_idle) return 0;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) begin
      calm = $urandom_range(20, 80);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic result_t predict_scaler(cmd_e cmd, logic [3:0][15:0] smp);
    int unsigned sw, dw, sh, dh, spp, col, rsum, nxt;
    int          i;
    logic        at_row_end, at_frame_end;
    result_t     res;
    sw  = eff_width(src_w_reg);
    dw  = eff_width(dst_w_reg);
    sh  = eff_height(src_h_reg);
    dh  = eff_height(dst_h_reg);
    spp = eff_samples(spp_reg);
    res = '0;
    if (cmd == CMD_WRITE) begin
      if (loaded_row == {1'b0, row_src}) begin
        res.meta.status = ST_REFUSED;
        return res;
      end
      col = wr_col;
      for (i = 0; i < NumSamplePorts; i++) begin
        pixel_line[col][i] = (i < spp) ? smp[i] : 16'h0;
      end
      if (col + 1 >= sw) begin
        loaded_row = {1'b0, wr_row};
        wr_col     = '0;
        wr_row     = (wr_row + 1 >= sh) ? 16'd0 : wr_row + 16'd1;
      end else begin
        loaded_row = NoRow;
        wr_col     = 12'(col + 1);
      end
      res.meta.status = ST_WRITE_OK;
      return res;
    end
    if (loaded_row != {1'b0, row_src}) begin
      res.meta.status = ST_WAIT;
      return res;
    end
    col = col_src;
    res.meta.status = ST_PIXEL;
    for (i = 0; i < spp; i++) res.samples[i] = pixel_line[col][i];
    at_row_end   = (fe_col + 1 >= dw);
    at_frame_end = at_row_end && (fe_row + 1 >= dh);
    res.meta.dest_x    = fe_col;
    res.meta.dest_y    = fe_row;
    res.meta.row_end   = at_row_end;
    res.meta.frame_end = at_frame_end;
    if (!at_row_end) begin
      fe_col = fe_col + 12'd1;
      rsum   = col_rem + sw % dw;
      nxt    = col_src + sw / dw;
      if (rsum >= dw) begin
        rsum -= dw;
        nxt++;
      end
      col_rem = 13'(rsum);
      col_src = 12'(nxt);
    end else begin
      fe_col  = '0;
      col_src = '0;
      col_rem = '0;
      if (at_frame_end) begin
        fe_row     = '0;
        row_src    = '0;
        row_rem    = '0;
        loaded_row = NoRow;
      end else begin
        fe_row = fe_row + 16'd1;
        rsum   = row_rem + sh % dh;
        nxt    = row_src + sh / dh;
        if (rsum >= dh) begin
          rsum -= dh;
          nxt++;
        end
        row_rem = 17'(rsum);
        row_src = 16'(nxt);
      end
    end
    return res;
  endfunction

  // Well-formed traffic: fetch when the needed row is loaded, else fill; some noise
  function automatic cmd_e pick_command();
    logic ready;
    ready = (loaded_row == {1'b0, row_src});
    if ($urandom_range(0, 99) < 8) ready = !ready;
    return ready ? CMD_FETCH : CMD_WRITE;
  endfunction

  function automatic logic [3:0][15:0] random_pixel();
    logic [3:0][15:0] p;
    p = {$urandom, $urandom};
    return p;
  endfunction

  task automatic push_command(cmd_e cmd, logic [3:0][15:0] smp);
    int gap;
    gap = pick_gap(send_calm);
    @(negedge clk_i);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    push         <= 1'b1;
    command_i    <= cmd;
    in_sample0_i <= smp[0];
    in_sample1_i <= smp[1];
    in_sample2_i <= smp[2];
    in_sample3_i <= smp[3];
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    pending_results.push_back(predict_scaler(cmd, smp));
  endtask

  task automatic hold_push_low();
    @(negedge clk_i);
    push <= 1'b0;
  endtask

  // Register writes happen only with nothing in flight
  task automatic write_register(cfg_idx_e idx, int unsigned value);
    logic [15:0] data;
    data = 16'($urandom);
    case (idx)
      REG_SRC_WIDTH, REG_DST_WIDTH: data[12:0] = value[12:0];
      REG_SAMPLES:                  data[2:0]  = value[2:0];
      default:                      data       = value[15:0];
    endcase
    hold_push_low();
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (3) @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_SRC_WIDTH:  src_w_reg = data[12:0];
      REG_SRC_HEIGHT: src_h_reg = data;
      REG_DST_WIDTH:  dst_w_reg = data[12:0];
      REG_DST_HEIGHT: dst_h_reg = data;
      REG_SAMPLES:    spp_reg   = data[2:0];
      default: ;
    endcase
    wr_col     = '0;
    wr_row     = '0;
    loaded_row = NoRow;
    fe_col     = '0;
    fe_row     = '0;
    col_src    = '0;
    col_rem    = '0;
    row_src    = '0;
    row_rem    = '0;
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  task automatic compare_result();
    result_t want;
    if (pending_results.size() == 0) begin
      $error("result with nothing pending: status %0d", status_o);
      mismatches++;
      return;
    end
    want = pending_results.pop_front();
    check_field("status", want.meta.status, status_o);
    check_field("out_sample0", want.samples[0], out_sample0_o);
    check_field("out_sample1", want.samples[1], out_sample1_o);
    check_field("out_sample2", want.samples[2], out_sample2_o);
    check_field("out_sample3", want.samples[3], out_sample3_o);
    check_field("dest_x", want.meta.dest_x, dest_x_o);
    check_field("dest_y", want.meta.dest_y, dest_y_o);
    check_field("row_end", want.meta.row_end, row_end_o);
    check_field("frame_end", want.meta.frame_end, frame_end_o);
  endtask

  initial begin : result_monitor
    int stall;
    int calm;
    stall = 0;
    calm  = 0;
    pop   = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall > 0) begin
        pop <= 1'b0;
        stall--;
      end else begin
        pop <= 1'b1;
        stall = pick_gap(calm);
      end
      @(posedge clk_i);
      if (rst_ni && pop && !empty) compare_result();
    end
  end

  // Defaults after reset: wait, write, refusal, single pixel at frame end, wait
  task automatic test_reset_defaults();
    push_command(CMD_FETCH, random_pixel());
    push_command(CMD_WRITE, {16'h0, 16'h0, 16'h0, 16'hFFFF});
    push_command(CMD_WRITE, random_pixel());
    push_command(CMD_FETCH, '0);
    push_command(CMD_FETCH, '1);
  endtask

  // Sample count: full, partial, zero and oversized settings
  task automatic test_sample_counts();
    write_register(REG_SRC_WIDTH, 0);
    write_register(REG_DST_HEIGHT, 0);
    write_register(REG_SAMPLES, 4);
    push_command(CMD_WRITE, '1);
    push_command(CMD_FETCH, '0);
    write_register(REG_SAMPLES, 3);
    push_command(CMD_WRITE, {16'hFFFF, 16'h8000, 16'h0001, 16'h7FFF});
    push_command(CMD_FETCH, '0);
    write_register(REG_SAMPLES, 0);
    push_command(CMD_WRITE, {16'hAAAA, 16'h5555, 16'h1234, 16'hFFFE});
    push_command(CMD_FETCH, '1);
    write_register(REG_SAMPLES, 7);
    push_command(CMD_WRITE, {16'h0F0F, 16'hF0F0, 16'hFFFF, 16'h0000});
    push_command(CMD_FETCH, '0);
  endtask

  // Upscale of one short row: repeated columns, row end, frame end, refill
  task automatic test_step_pattern();
    write_register(REG_SRC_WIDTH, 2);
    write_register(REG_DST_WIDTH, 3);
    write_register(REG_SRC_HEIGHT, 1);
    write_register(REG_DST_HEIGHT, 2);
    write_register(REG_SAMPLES, 2);
    push_command(CMD_WRITE, random_pixel());
    push_command(CMD_WRITE, random_pixel());
    repeat (6) push_command(CMD_FETCH, random_pixel());
    push_command(CMD_FETCH, random_pixel());
    push_command(CMD_WRITE, random_pixel());
  endtask

  // Tallest destination and tallest source with small rows
  task automatic test_height_extremes();
    write_register(REG_SRC_WIDTH, 1);
    write_register(REG_DST_WIDTH, 1);
    write_register(REG_SRC_HEIGHT, 1);
    write_register(REG_DST_HEIGHT, 65535);
    push_command(CMD_WRITE, random_pixel());
    repeat (6) push_command(CMD_FETCH, random_pixel());
    write_register(REG_SRC_HEIGHT, 65535);
    write_register(REG_DST_HEIGHT, 0);
    push_command(CMD_WRITE, random_pixel());
    push_command(CMD_FETCH, random_pixel());
    repeat (3) push_command(CMD_WRITE, random_pixel());
    push_command(CMD_FETCH, random_pixel());
  endtask

  // Oversized widths on both sides, back to back
  task automatic test_oversized_width();
    no_idle = 1'b1;
    write_register(REG_SRC_WIDTH, 8191);
    write_register(REG_DST_WIDTH, 1);
    write_register(REG_SRC_HEIGHT, 2);
    write_register(REG_DST_HEIGHT, 3);
    write_register(REG_SAMPLES, 4);
    repeat (24) push_command(CMD_WRITE, random_pixel());
    push_command(CMD_FETCH, random_pixel());
    write_register(REG_SRC_WIDTH, 1);
    write_register(REG_DST_WIDTH, 8191);
    push_command(CMD_WRITE, random_pixel());
    repeat (24) push_command(CMD_FETCH, random_pixel());
    push_command(CMD_WRITE, random_pixel());
    no_idle = 1'b0;
  endtask

  task automatic test_random_frames();
    int unsigned sent;
    int unsigned burst;
    bit          first;
    sent  = 0;
    first = 1'b1;
    while (sent < 750) begin
      if (first || $urandom_range(0, 3) != 0)
        write_register(REG_SRC_WIDTH, ($urandom_range(0, 5) == 0) ?
                       $urandom_range(9, 40) : $urandom_range(0, 8));
      if (first || $urandom_range(0, 3) != 0)
        write_register(REG_DST_WIDTH, ($urandom_range(0, 5) == 0) ?
                       $urandom_range(9, 40) : $urandom_range(0, 8));
      if (first || $urandom_range(0, 3) != 0)
        write_register(REG_SRC_HEIGHT, $urandom_range(0, 6));
      if (first || $urandom_range(0, 3) != 0)
        write_register(REG_DST_HEIGHT, $urandom_range(0, 6));
      if (first || $urandom_range(0, 3) != 0)
        write_register(REG_SAMPLES, $urandom_range(0, 7));
      first = 1'b0;
      burst = $urandom_range(60, 110);
      repeat (burst) push_command(pick_command(), random_pixel());
      sent += burst;
    end
  endtask

  initial begin : stimulus
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = '0;
    cfg_data_i   = '0;
    push         = 1'b0;
    command_i    = 1'b0;
    in_sample0_i = '0;
    in_sample1_i = '0;
    in_sample2_i = '0;
    in_sample3_i = '0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_defaults();
    test_sample_counts();
    test_step_pattern();
    test_height_extremes();
    test_oversized_width();
    test_random_frames();

    hold_push_low();
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (mismatches == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  initial begin : watchdog
    #10_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
